// ===== sv/pscc_pkg.sv =====
// Shared types and constants for the polyline sphere collision check.
package pscc_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 24;
    localparam int T_FRAC_BITS_DEF = 16;

    localparam int TUBE_W     = 24;
    localparam int LIMIT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_TUBE_THICKNESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGENERATE_LIMIT = 2'd1;

    localparam logic [TUBE_W-1:0]  TUBE_RESET  = 24'd0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1;

    typedef enum logic [1:0] {
        K_LOAD         = 2'd0,
        K_LOAD_RESTART = 2'd1,
        K_QUERY        = 2'd2
    } t_kind;

endpackage

// ===== sv/pscc_front.sv =====
// Input side: accepts items, classifies them and queues them for the back end.
module pscc_front #(
    parameter int COORD_BITS = pscc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_func,
    input  logic                         i_restart,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic        [COORD_BITS-2:0] i_sphere_radius,
    output logic                         o_item_valid,
    input  logic                         i_item_take,
    output pscc_pkg::t_kind              o_kind,
    output logic        [4*COORD_BITS-2:0] o_item
);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int IW    = 4*COORD_BITS-1;

    logic [IW-1:0]        r_data [DEPTH];
    pscc_pkg::t_kind      r_kind [DEPTH];
    logic [PW-1:0]        r_wr, r_rd;
    logic [PW:0]          r_cnt;
    logic                 push, pop;
    pscc_pkg::t_kind      kind;

    always_comb begin
        if (i_func) begin
            kind = pscc_pkg::K_QUERY;
        end else if (i_restart) begin
            kind = pscc_pkg::K_LOAD_RESTART;
        end else begin
            kind = pscc_pkg::K_LOAD;
        end
    end

    assign o_stall      = (r_cnt == (PW+1)'(DEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign push         = i_valid && !o_stall;
    assign pop          = o_item_valid && i_item_take;
    assign o_kind       = r_kind[r_rd];
    assign o_item       = r_data[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wr] <= {i_pos_x, i_pos_y, i_pos_z, i_sphere_radius};
            r_kind[r_wr] <= kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/pscc_back.sv =====
// Back end: point store, segment walk with projection divider, result register.
module pscc_back #(
    parameter int MAX_POINTS  = pscc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS  = pscc_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = pscc_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_item_valid,
    output logic                                o_item_take,
    input  pscc_pkg::t_kind                     i_kind,
    input  logic        [4*COORD_BITS-2:0]      i_item,
    input  logic        [pscc_pkg::TUBE_W-1:0]  i_tube,
    input  logic        [pscc_pkg::LIMIT_W-1:0] i_limit,
    output logic                                o_valid,
    input  logic                                i_out_take,
    output logic                                o_collides,
    output logic signed [COORD_BITS-1:0]        o_near_x,
    output logic signed [COORD_BITS-1:0]        o_near_y,
    output logic signed [COORD_BITS-1:0]        o_near_z,
    output logic        [$clog2(MAX_POINTS+1)-1:0] o_stored_count,
    output logic                                o_load_dropped
);
    localparam int CW    = COORD_BITS;
    localparam int F     = T_FRAC_BITS;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS+1);
    localparam int LW    = 2*CW+2;
    localparam int PW    = CW+F+2;
    localparam int SW    = $clog2(F);
    localparam int CLW   = ((CW > pscc_pkg::TUBE_W) ? CW : pscc_pkg::TUBE_W) + 1;
    localparam int CMPW  = (2*CLW > LW+2) ? 2*CLW : LW+2;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_P0   = 14'b00000000000010,
        S_SEG  = 14'b00000000000100,
        S_MUL  = 14'b00000000001000,
        S_SUM  = 14'b00000000010000,
        S_CHK  = 14'b00000000100000,
        S_DIV  = 14'b00000001000000,
        S_OFF  = 14'b00000010000000,
        S_CPT  = 14'b00000100000000,
        S_DST  = 14'b00001000000000,
        S_DSUM = 14'b00010000000000,
        S_FIN  = 14'b00100000000000,
        S_FSUM = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic signed [CW-1:0] mem_x [MAX_POINTS];
    logic signed [CW-1:0] mem_y [MAX_POINTS];
    logic signed [CW-1:0] mem_z [MAX_POINTS];
    logic signed [CW-1:0] rd_x, rd_y, rd_z;

    logic [AW-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt;
    logic             r_have;

    logic signed [CW-1:0] r_px, r_py, r_pz;
    logic        [CW-2:0] r_rad;
    logic signed [CW-1:0] r_ax, r_ay, r_az;   // segment start
    logic signed [CW-1:0] r_bx, r_by, r_bz;   // segment end
    logic signed [CW:0]   r_sx, r_sy, r_sz;
    logic signed [CW:0]   r_qx, r_qy, r_qz;
    logic signed [LW-1:0] r_lx, r_ly, r_lz;
    logic signed [LW-1:0] r_ux, r_uy, r_uz;
    logic        [LW-1:0] r_len;
    logic signed [LW:0]   r_dot;
    logic        [LW:0]   r_rem;
    logic        [F:0]    r_t;
    logic        [SW-1:0] r_step;
    logic        [PW-1:0] r_ox, r_oy, r_oz;
    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    logic signed [LW-1:0] r_ex, r_ey, r_ez;
    logic        [LW-1:0] r_best;
    logic        [2*CLW-1:0] r_clr2;

    logic signed [CW-1:0] r_nx, r_ny, r_nz;
    logic                 r_coll, r_drop;

    logic             take, is_load, full, we, more;
    logic [CNT_W-1:0] eff_cnt;
    logic signed [LW:0] len_sum, dot_sum, e_sum;
    logic [LW:0]      sh;
    logic [CLW-1:0]   clr;

    function automatic logic [CW:0] mag(input logic signed [CW:0] v);
        mag = v[CW] ? -v : v;
    endfunction

    function automatic logic signed [CW-1:0] place(input logic signed [CW-1:0] base,
                                                   input logic signed [CW:0]   seg,
                                                   input logic [PW-1:0]        prod);
        logic [PW-1:0]       rnd;
        logic signed [CW+1:0] qs;
        logic signed [CW+1:0] sum;
        rnd   = prod + PW'(1 << (F-1));
        qs    = {1'b0, rnd[F+CW:F]};
        sum   = {base[CW-1], base[CW-1], base} + (seg[CW] ? -qs : qs);
        place = sum[CW-1:0];
    endfunction

    assign take    = (r_state == S_IDLE) && i_item_valid;
    assign o_item_take = take;
    assign is_load = (i_kind != pscc_pkg::K_QUERY);
    assign eff_cnt = (i_kind == pscc_pkg::K_LOAD_RESTART) ? '0 : r_cnt;
    assign full    = (eff_cnt == CNT_W'(MAX_POINTS));
    assign we      = take && is_load && !full;
    assign more    = (CNT_W'(r_idx) + 1'b1) < r_cnt;

    assign len_sum = r_lx + r_ly + r_lz;
    assign dot_sum = r_ux + r_uy + r_uz;
    assign e_sum   = r_ex + r_ey + r_ez;
    assign sh      = {r_rem[LW-1:0], 1'b0};
    assign clr     = (CLW'(r_rad) << 1) + CLW'(i_tube);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (is_load) begin
                        n_state = S_OUT;
                    end else if (r_cnt == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = '0;
                        n_state = S_P0;
                    end
                end
            end
            S_P0: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = AW'(1);
                    n_state = S_SEG;
                end
            end
            S_SEG: n_state = S_MUL;
            S_MUL: n_state = S_SUM;
            S_SUM: n_state = S_CHK;
            S_CHK: begin
                if (r_len < LW'(i_limit) || r_len == '0) begin
                    if (more) begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SEG;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (r_dot[LW] || r_dot == '0) begin
                    n_state = S_OFF;
                end else if (r_dot[LW-1:0] >= r_len) begin
                    n_state = S_OFF;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == SW'(F-1)) n_state = S_OFF;
            end
            S_OFF: n_state = S_CPT;
            S_CPT: n_state = S_DST;
            S_DST: n_state = S_DSUM;
            S_DSUM: begin
                if (more) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SEG;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN:  n_state = S_FSUM;
            S_FSUM: n_state = S_OUT;
            S_OUT: begin
                if (i_out_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // point store, registered read of the point at n_idx
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_x[eff_cnt[AW-1:0]] <= i_item[4*CW-2 -: CW];
            mem_y[eff_cnt[AW-1:0]] <= i_item[3*CW-2 -: CW];
            mem_z[eff_cnt[AW-1:0]] <= i_item[2*CW-2 -: CW];
        end
        rd_x <= mem_x[n_idx];
        rd_y <= mem_y[n_idx];
        rd_z <= mem_z[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (take && is_load) r_cnt <= full ? eff_cnt : eff_cnt + 1'b1;
            if (r_state == S_P0) r_have <= 1'b0;
            if (r_state == S_DSUM && (!r_have || e_sum[LW-1:0] < r_best)) r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    r_px   <= i_item[4*CW-2 -: CW];
                    r_py   <= i_item[3*CW-2 -: CW];
                    r_pz   <= i_item[2*CW-2 -: CW];
                    r_rad  <= i_item[CW-2:0];
                    r_nx   <= '0;
                    r_ny   <= '0;
                    r_nz   <= '0;
                    r_coll <= 1'b0;
                    r_drop <= is_load && full;
                end
            end
            S_P0: begin
                r_ax <= rd_x; r_ay <= rd_y; r_az <= rd_z;
                r_nx <= rd_x; r_ny <= rd_y; r_nz <= rd_z;
            end
            S_SEG: begin
                r_bx <= rd_x; r_by <= rd_y; r_bz <= rd_z;
                r_sx <= (CW+1)'(rd_x) - (CW+1)'(r_ax);
                r_sy <= (CW+1)'(rd_y) - (CW+1)'(r_ay);
                r_sz <= (CW+1)'(rd_z) - (CW+1)'(r_az);
                r_qx <= (CW+1)'(r_px) - (CW+1)'(r_ax);
                r_qy <= (CW+1)'(r_py) - (CW+1)'(r_ay);
                r_qz <= (CW+1)'(r_pz) - (CW+1)'(r_az);
            end
            S_MUL: begin
                r_lx <= r_sx * r_sx; r_ly <= r_sy * r_sy; r_lz <= r_sz * r_sz;
                r_ux <= r_qx * r_sx; r_uy <= r_qy * r_sy; r_uz <= r_qz * r_sz;
            end
            S_SUM: begin
                r_len <= len_sum[LW-1:0];
                r_dot <= dot_sum;
            end
            S_CHK: begin
                r_rem  <= {1'b0, r_dot[LW-1:0]};
                r_step <= '0;
                if (r_dot[LW] || r_dot == '0) begin
                    r_t <= '0;
                end else if (r_dot[LW-1:0] >= r_len) begin
                    r_t <= (F+1)'(1) << F;
                end else begin
                    r_t <= '0;
                end
                if (r_len < LW'(i_limit) || r_len == '0) begin
                    r_ax <= r_bx; r_ay <= r_by; r_az <= r_bz;
                end
            end
            S_DIV: begin
                r_step <= r_step + 1'b1;
                if (sh >= {1'b0, r_len}) begin
                    r_rem <= sh - {1'b0, r_len};
                    r_t   <= {r_t[F-1:0], 1'b1};
                end else begin
                    r_rem <= sh;
                    r_t   <= {r_t[F-1:0], 1'b0};
                end
            end
            S_OFF: begin
                r_ox <= PW'(mag(r_sx)) * PW'(r_t);
                r_oy <= PW'(mag(r_sy)) * PW'(r_t);
                r_oz <= PW'(mag(r_sz)) * PW'(r_t);
            end
            S_CPT: begin
                r_cx <= place(r_ax, r_sx, r_ox);
                r_cy <= place(r_ay, r_sy, r_oy);
                r_cz <= place(r_az, r_sz, r_oz);
            end
            S_DST: begin
                r_ex <= ((CW+1)'(r_px) - (CW+1)'(r_cx)) * ((CW+1)'(r_px) - (CW+1)'(r_cx));
                r_ey <= ((CW+1)'(r_py) - (CW+1)'(r_cy)) * ((CW+1)'(r_py) - (CW+1)'(r_cy));
                r_ez <= ((CW+1)'(r_pz) - (CW+1)'(r_cz)) * ((CW+1)'(r_pz) - (CW+1)'(r_cz));
            end
            S_DSUM: begin
                if (!r_have || e_sum[LW-1:0] < r_best) begin
                    r_best <= e_sum[LW-1:0];
                    r_nx   <= r_cx; r_ny <= r_cy; r_nz <= r_cz;
                end
                r_ax <= r_bx; r_ay <= r_by; r_az <= r_bz;
            end
            S_FIN: begin
                r_ex   <= ((CW+1)'(r_px) - (CW+1)'(r_nx)) * ((CW+1)'(r_px) - (CW+1)'(r_nx));
                r_ey   <= ((CW+1)'(r_py) - (CW+1)'(r_ny)) * ((CW+1)'(r_py) - (CW+1)'(r_ny));
                r_ez   <= ((CW+1)'(r_pz) - (CW+1)'(r_nz)) * ((CW+1)'(r_pz) - (CW+1)'(r_nz));
                r_clr2 <= (2*CLW)'(clr) * (2*CLW)'(clr);
            end
            S_FSUM: begin
                r_coll <= (CMPW'(e_sum[LW-1:0]) << 2) < CMPW'(r_clr2);
            end
            default: ;
        endcase
    end

    assign o_valid        = (r_state == S_OUT);
    assign o_collides     = r_coll;
    assign o_near_x       = r_nx;
    assign o_near_y       = r_ny;
    assign o_near_z       = r_nz;
    assign o_stored_count = r_cnt;
    assign o_load_dropped = r_drop;

endmodule

// ===== sv/polyline_sphere_collision_check.sv =====
// Top level: polyline store and sphere-to-polyline closest point / collision test.
// A load goes from the queue straight to its result transaction. A query walks the stored
// segments in turn, in the worst case each through the one-bit-per-cycle projection
// divider (an empty list goes straight to the final check); skipped segments and
// segments whose projection clamps skip the divider. A four-entry queue accepts new
// items while the back end walks, and the result is held until taken.
// Configuration: index 0 tube thickness, index 1 degenerate length limit; write only idle.
module polyline_sphere_collision_check #(
    parameter int MAX_POINTS      = pscc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS      = pscc_pkg::COORD_BITS_DEF,
    parameter int T_FRACTION_BITS = pscc_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_func,
    input  logic                                   i_restart,
    input  logic signed [COORD_BITS-1:0]           i_pos_x,
    input  logic signed [COORD_BITS-1:0]           i_pos_y,
    input  logic signed [COORD_BITS-1:0]           i_pos_z,
    input  logic        [COORD_BITS-2:0]           i_sphere_radius,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_collides,
    output logic signed [COORD_BITS-1:0]           o_near_x,
    output logic signed [COORD_BITS-1:0]           o_near_y,
    output logic signed [COORD_BITS-1:0]           o_near_z,
    output logic        [$clog2(MAX_POINTS+1)-1:0] o_stored_count,
    output logic                                   o_load_dropped,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [pscc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [pscc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    logic [pscc_pkg::TUBE_W-1:0]  r_tube;
    logic [pscc_pkg::LIMIT_W-1:0] r_limit;
    logic                         item_valid, item_take;
    pscc_pkg::t_kind              kind;
    logic [4*COORD_BITS-2:0]      item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tube  <= pscc_pkg::TUBE_RESET;
            r_limit <= pscc_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pscc_pkg::CFG_TUBE_THICKNESS:
                    r_tube <= i_cfg_data[pscc_pkg::TUBE_W-1:0];
                pscc_pkg::CFG_DEGENERATE_LIMIT:
                    r_limit <= i_cfg_data[pscc_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    pscc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_restart       (i_restart),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_sphere_radius (i_sphere_radius),
        .o_item_valid    (item_valid),
        .i_item_take     (item_take),
        .o_kind          (kind),
        .o_item          (item)
    );

    pscc_back #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRACTION_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (item_valid),
        .o_item_take    (item_take),
        .i_kind         (kind),
        .i_item         (item),
        .i_tube         (r_tube),
        .i_limit        (r_limit),
        .o_valid        (o_valid),
        .i_out_take     (!i_stall),
        .o_collides     (o_collides),
        .o_near_x       (o_near_x),
        .o_near_y       (o_near_y),
        .o_near_z       (o_near_z),
        .o_stored_count (o_stored_count),
        .o_load_dropped (o_load_dropped)
    );

endmodule

// ===== verif/pscc_checker.sv =====
`timescale 1ns / 1ps
// Checker for the polyline sphere collision check: predicts every result and compares.
module pscc_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic                                  i_stall_in,
    input  logic                                  i_func,
    input  logic                                  i_restart,
    input  logic signed [23:0]                    i_pos_x,
    input  logic signed [23:0]                    i_pos_y,
    input  logic signed [23:0]                    i_pos_z,
    input  logic        [22:0]                    i_sphere_radius,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  logic                                  i_collides,
    input  logic signed [23:0]                    i_near_x,
    input  logic signed [23:0]                    i_near_y,
    input  logic signed [23:0]                    i_near_z,
    input  logic        [6:0]                     i_stored_count,
    input  logic                                  i_load_dropped,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic        [pscc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [pscc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    localparam int NPTS = pscc_pkg::MAX_POINTS_DEF;
    localparam int TFB  = pscc_pkg::T_FRAC_BITS_DEF;

    typedef struct packed {
        logic        collides;
        logic [23:0] nx;
        logic [23:0] ny;
        logic [23:0] nz;
        logic [6:0]  count;
        logic        dropped;
    } t_answer;

    longint   pt_x [NPTS];
    longint   pt_y [NPTS];
    longint   pt_z [NPTS];
    int       n_points;
    longint   thickness;
    longint   min_len_sq;
    t_answer  answer_q[$];

    function automatic longint sq(longint v);
        return v * v;
    endfunction

    // t*seg / 2^TFB rounded to nearest, ties away from zero
    function automatic longint along(longint seg, longint t);
        longint a;
        longint q;
        a = (seg < 0) ? -seg : seg;
        q = (a * t + (64'sd1 <<< (TFB - 1))) >>> TFB;
        return (seg < 0) ? -q : q;
    endfunction

    task automatic predict(input logic func, input logic restart,
                           input longint px, input longint py, input longint pz,
                           input longint rad, output t_answer res);
        longint nx, ny, nz, sx, sy, sz, qx, qy, qz, len, dot, t, rem;
        longint cx, cy, cz, seg_d2, best, d2, clear;
        bit     have;
        int     i;
        int     b;
        nx = 0; ny = 0; nz = 0;
        res = '0;
        if (!func) begin
            if (restart) n_points = 0;
            if (n_points >= NPTS) begin
                res.dropped = 1'b1;
            end else begin
                pt_x[n_points] = px;
                pt_y[n_points] = py;
                pt_z[n_points] = pz;
                n_points++;
            end
        end else begin
            if (n_points > 0) begin
                have = 0;
                best = 0;
                nx = pt_x[0]; ny = pt_y[0]; nz = pt_z[0];
                for (i = 0; i + 1 < n_points; i++) begin
                    sx = pt_x[i+1] - pt_x[i];
                    sy = pt_y[i+1] - pt_y[i];
                    sz = pt_z[i+1] - pt_z[i];
                    len = sq(sx) + sq(sy) + sq(sz);
                    if (len < min_len_sq || len == 0) continue;
                    qx = px - pt_x[i];
                    qy = py - pt_y[i];
                    qz = pz - pt_z[i];
                    dot = qx * sx + qy * sy + qz * sz;
                    if (dot <= 0) begin
                        t = 0;
                    end else if (dot >= len) begin
                        t = 64'sd1 <<< TFB;
                    end else begin
                        rem = dot;
                        t = 0;
                        for (b = 0; b < TFB; b++) begin
                            rem = rem <<< 1;
                            t = t <<< 1;
                            if (rem >= len) begin
                                rem = rem - len;
                                t = t | 1;
                            end
                        end
                    end
                    cx = pt_x[i] + along(sx, t);
                    cy = pt_y[i] + along(sy, t);
                    cz = pt_z[i] + along(sz, t);
                    seg_d2 = sq(px - cx) + sq(py - cy) + sq(pz - cz);
                    if (!have || seg_d2 < best) begin
                        have = 1;
                        best = seg_d2;
                        nx = cx; ny = cy; nz = cz;
                    end
                end
            end
            d2 = sq(px - nx) + sq(py - ny) + sq(pz - nz);
            clear = 2 * rad + thickness;
            res.collides = (4 * d2 < clear * clear);
        end
        res.nx = nx[23:0];
        res.ny = ny[23:0];
        res.nz = nz[23:0];
        res.count = n_points[6:0];
    endtask

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            n_points      = 0;
            thickness    <= longint'(pscc_pkg::TUBE_RESET);
            min_len_sq   <= longint'(pscc_pkg::LIMIT_RESET);
            o_fail_count <= 0;
            o_pending    <= 0;
            answer_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_collides, i_near_x, i_near_y, i_near_z, i_stored_count,
                       i_load_dropped};
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected col=%0d near=(%h,%h,%h) cnt=%0d drop=%0d",
                                 $time, want.collides, want.nx, want.ny, want.nz,
                                 want.count, want.dropped);
                        $display("%0t:          actual   col=%0d near=(%h,%h,%h) cnt=%0d drop=%0d",
                                 $time, got.collides, got.nx, got.ny, got.nz,
                                 got.count, got.dropped);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !i_stall_in) begin
                predict(i_func, i_restart, longint'(i_pos_x), longint'(i_pos_y),
                        longint'(i_pos_z), longint'(i_sphere_radius), want);
                answer_q.insert(answer_q.size(), want);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == pscc_pkg::CFG_TUBE_THICKNESS)
                    thickness <= longint'(i_cfg_data[pscc_pkg::TUBE_W-1:0]);
                else if (i_cfg_index == pscc_pkg::CFG_DEGENERATE_LIMIT)
                    min_len_sq <= longint'(i_cfg_data[pscc_pkg::LIMIT_W-1:0]);
            end
            o_pending <= answer_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: stimulus, output back-pressure, watchdog and verdict.
module tb_top;

    localparam int WATCHDOG = 20000;
    localparam int TAIL     = 2000;
    localparam int N_PHASES = 8;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic                   i_func = 1'b0;
    logic                   i_restart = 1'b0;
    logic signed [23:0]     i_pos_x = '0;
    logic signed [23:0]     i_pos_y = '0;
    logic signed [23:0]     i_pos_z = '0;
    logic        [22:0]     i_sphere_radius = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic                   o_collides;
    logic signed [23:0]     o_near_x, o_near_y, o_near_z;
    logic        [6:0]      o_stored_count;
    logic                   o_load_dropped;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [pscc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [pscc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int n_loads = 0;
    int n_queries = 0;
    int n_cfg = 0;
    int idle_cnt = 0;
    int hold = 0;
    bit quiet = 0;
    logic signed [23:0] last_x = '0, last_y = '0, last_z = '0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    polyline_sphere_collision_check i_dut (.*);

    pscc_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_func, .i_restart,
        .i_pos_x, .i_pos_y, .i_pos_z, .i_sphere_radius,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_collides(o_collides),
        .i_near_x(o_near_x), .i_near_y(o_near_y), .i_near_z(o_near_z),
        .i_stored_count(o_stored_count), .i_load_dropped(o_load_dropped),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // result side: random back-pressure drawn after each transaction
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            hold    <= 0;
            i_stall <= 1'b0;
        end else if (o_valid && !i_stall) begin
            n = quiet ? 0 : $urandom_range(0, 7);
            hold    <= n;
            i_stall <= (n != 0);
        end else if (hold != 0) begin
            hold    <= hold - 1;
            i_stall <= (hold > 1);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send(input logic func, input logic restart, input logic signed [23:0] x,
                        input logic signed [23:0] y, input logic signed [23:0] z,
                        input logic [22:0] rad);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_func          <= func;
        i_restart       <= restart;
        i_pos_x         <= x;
        i_pos_y         <= y;
        i_pos_z         <= z;
        i_sphere_radius <= rad;
        do @(posedge i_clk); while (o_stall);
        if (func) begin
            n_queries++;
        end else begin
            n_loads++;
            last_x = x; last_y = y; last_z = z;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [pscc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pscc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        n_cfg++;
    endtask

    function automatic logic signed [23:0] near_coord(input logic signed [23:0] c);
        case ($urandom_range(0, 3))
            0:       return c;
            1:       return c + 24'(int'($urandom_range(0, 16)) - 8);
            2:       return c + 24'(int'($urandom_range(0, 32767)) - 16384);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [22:0] rand_radius();
        case ($urandom_range(0, 3))
            0:       return 23'($urandom);
            1:       return 23'($urandom_range(0, 65535));
            2:       return 23'($urandom_range(0, 255));
            default: return 23'($urandom_range(0, 8192));
        endcase
    endfunction

    task automatic load_near(input logic restart);
        send(1'b0, restart, near_coord(last_x), near_coord(last_y), near_coord(last_z),
             23'($urandom));
    endtask

    task automatic query_near();
        send(1'b1, 1'($urandom), near_coord(last_x), near_coord(last_y), near_coord(last_z),
             rand_radius());
    endtask

    initial begin
        logic signed [23:0] smax, smin;
        int k, nq, phase, quota;
        smax = 24'sh7FFFFF;
        smin = 24'sh800000;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, single point, extremes, degenerate and unit segments
        send(1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0, 23'd0);
        send(1'b1, 1'b1, smax, smin, smax, 23'h7FFFFF);
        send(1'b0, 1'b1, smax, smax, smax, 23'h7FFFFF);
        send(1'b1, 1'b0, smax - 24'sd5, smax, smax, 23'h7FFFFF);
        send(1'b1, 1'b0, smax, smax, smax, 23'd0);
        send(1'b0, 1'b0, smin, smin, smin, 23'd0);
        send(1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0, 23'd0);
        send(1'b1, 1'b0, smax, smin, 24'sd0, 23'h7FFFFF);
        send(1'b1, 1'b0, smin, smin, smin, 23'd1);
        send(1'b0, 1'b1, 24'sd100, -24'sd100, 24'sd7, 23'd0);
        send(1'b0, 1'b0, 24'sd100, -24'sd100, 24'sd7, 23'd0);
        send(1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0, 23'd200);
        send(1'b0, 1'b0, 24'sd101, -24'sd100, 24'sd7, 23'd0);
        send(1'b1, 1'b0, 24'sd101, 24'sd0, 24'sd7, 23'd100);
        send(1'b0, 1'b0, smax, 24'sd0, smin, 23'd0);
        send(1'b1, 1'b0, 24'sd4096, -24'sd4096, 24'sd0, 23'd4096);
        send(1'b1, 1'b0, 24'sd100, -24'sd100, 24'sd7, 23'd0);
        drain();

        // one pass per register setting; each phase drains before the next write
        quota = 240;
        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase % 4)
                0:       cfg_write(pscc_pkg::CFG_TUBE_THICKNESS, 24'd0);
                1:       cfg_write(pscc_pkg::CFG_TUBE_THICKNESS, 24'hFFFFFF);
                2:       cfg_write(pscc_pkg::CFG_TUBE_THICKNESS, 24'($urandom));
                default: cfg_write(pscc_pkg::CFG_TUBE_THICKNESS, 24'($urandom_range(0, 20000)));
            endcase
            case ((phase / 2) % 4)
                0:       cfg_write(pscc_pkg::CFG_DEGENERATE_LIMIT, 24'd1);
                1:       cfg_write(pscc_pkg::CFG_DEGENERATE_LIMIT, 24'hFF0000);
                2:       cfg_write(pscc_pkg::CFG_DEGENERATE_LIMIT, 24'hFFFFFF);
                default: cfg_write(pscc_pkg::CFG_DEGENERATE_LIMIT, 24'($urandom));
            endcase
            if (phase == 3) cfg_write(pscc_pkg::CFG_IDX_W'(3), 24'($urandom));
            if (phase == 5) cfg_write(pscc_pkg::CFG_IDX_W'(2), 24'($urandom));
            quiet = (phase == 2);
            k = n_loads + n_queries + quota;
            while (n_loads + n_queries < k) begin
                if ($urandom_range(0, 99) < 85) begin
                    case ($urandom_range(0, 19))
                        0:       nq = $urandom_range(60, 67);
                        1, 2:    nq = 0;
                        default: nq = $urandom_range(1, 6);
                    endcase
                    if (nq > 0) begin
                        if ($urandom_range(0, 3) == 0)
                            send(1'b0, 1'b1, 24'($urandom), 24'($urandom), 24'($urandom),
                                 23'($urandom));
                        else
                            load_near(1'b1);
                        repeat (nq - 1) load_near(1'b0);
                    end
                    repeat ((nq >= 60) ? 1 : $urandom_range(1, 4)) query_near();
                end else begin
                    send(1'($urandom), 1'($urandom), 24'($urandom), 24'($urandom),
                         24'($urandom), 23'($urandom));
                end
            end
            drain();
        end

        repeat (TAIL) @(posedge i_clk);
        $display("Covered %0d loads and %0d queries over %0d register writes,", n_loads,
                 n_queries, n_cfg);
        $display("including empty, single-point, degenerate and full-store polylines.");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d failures, %0d results never arrived", fail_count, pending);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
